/* rtl/core/rsq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_pkg
// Shared types and constants for the RF squelch and ASK command detector.
// ----------------------------------------------------------------------------
package rsq_pkg;

  // sample path
  localparam int SAMPLE_BITS = 10;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

  // noise ring, depth is a power of two so the average is a shift
  localparam int RING_AW    = 7;
  localparam int RING_DEPTH = 1 << RING_AW;
  localparam int SUM_W      = SAMPLE_BITS + RING_AW;

  // ask decoder
  localparam int BIT_TOTAL_W = 6;
  localparam logic [BIT_TOTAL_W-1:0] BIT_TOTAL_MAX = {BIT_TOTAL_W{1'b1}};
  localparam logic [BIT_TOTAL_W-1:0] COMMAND_BITS  = BIT_TOTAL_W'(32);

  // keying
  localparam int KEYED_W = 16;
  localparam logic [KEYED_W-1:0] KEYED_MAX = {KEYED_W{1'b1}};

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
  typedef logic [7:0]             count8_t;
  typedef logic [KEYED_W-1:0]     keyed_t;

  // register indexes
  localparam cfg_idx_t REG_BASE_THRESHOLD     = 3'd0;
  localparam cfg_idx_t REG_ADAPTIVE_ENABLE    = 3'd1;
  localparam cfg_idx_t REG_ACTIVATION_COUNT   = 3'd2;
  localparam cfg_idx_t REG_HOLD_TICKS         = 3'd3;
  localparam cfg_idx_t REG_HALF_SECOND_TICKS  = 3'd4;
  localparam cfg_idx_t REG_SHORT_PERIOD_TICKS = 3'd5;

  // register reset values
  localparam sample_t RST_BASE_THRESHOLD     = SAMPLE_BITS'(50);
  localparam count8_t RST_ACTIVATION_COUNT   = 8'd3;
  localparam keyed_t  RST_HOLD_TICKS         = 16'd1000;
  localparam count8_t RST_HALF_SECOND_TICKS  = 8'd50;
  localparam count8_t RST_SHORT_PERIOD_TICKS = 8'd1;

endpackage

/* rtl/core/rf_squelch_ask_command_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_squelch_ask_command_detector
// RF squelch with repeater keying, adaptive noise floor, ASK command decode
// and a blink/watchdog tick counter.
// ----------------------------------------------------------------------------
// One sample transfer in gives one result transfer out. The block takes a new
// sample every clock cycle while the output side is ready; a sample is held in
// an input register and its result is registered in the output register. The
// noise ring is a 128 x 10 RAM with registered read; the entry to be replaced
// is prefetched from the current ring position, so the ring read never stalls
// the sample path. Configuration writes are taken in any cycle and should only
// be made while the block has no sample in flight.
// ----------------------------------------------------------------------------
module rf_squelch_ask_command_detector (
  input  logic               clk,
  input  logic               rst_n,
  // sample channel
  input  logic               in_valid,
  output logic               in_ready,
  input  rsq_pkg::sample_t   in_adc_sample,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ptt_on,
  output logic               out_signal_high,
  output logic               out_command_pending,
  output logic               out_led_on,
  output logic               out_watchdog_pin,
  output logic               out_watchdog_clear,
  output rsq_pkg::sample_t   out_threshold_used,
  output rsq_pkg::sample_t   out_noise_floor,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  rsq_pkg::cfg_idx_t  cfg_index,
  input  rsq_pkg::cfg_data_t cfg_data
);

  import rsq_pkg::*;

  // configuration registers
  sample_t base_threshold_r;
  logic    adaptive_enable_r;
  count8_t activation_count_r;
  keyed_t  hold_ticks_r;
  count8_t half_second_ticks_r;
  count8_t short_period_ticks_r;

  // handshake registers
  logic    in_valid_r;
  sample_t in_sample_r;
  logic    out_valid_r;

  // tick state
  count8_t tick_count_r, tick_count_nxt;
  logic    led_level_r, led_level_nxt;
  logic    wd_pin_r;
  logic    pending_r, pending_nxt;

  // noise floor state
  logic [RING_AW-1:0] ring_pos_r, ring_pos_nxt;
  logic [RING_AW:0]   ring_fill_r, ring_fill_nxt;
  logic [SUM_W-1:0]   ring_sum_r, ring_sum_nxt;
  sample_t            floor_r, floor_nxt;
  sample_t            ring_oldest;

  // keying state
  count8_t high_run_r, high_run_nxt;
  keyed_t  keyed_ticks_r, keyed_ticks_nxt;
  logic    tx_keyed_r, tx_keyed_nxt;

  // decoder state
  logic                   cur_level_r;
  logic                   busy_r, busy_nxt;
  logic                   slot_r, slot_nxt;
  logic [BIT_TOTAL_W-1:0] bit_total_r, bit_total_nxt;

  // per-tick combinational results
  logic    step;
  logic    ring_full;
  logic    high;
  logic    wd_clear;
  sample_t thr;
  logic    ring_we;

  // handshake: input register frees up whenever the output can take a result
  assign step      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  assign ring_full = (ring_fill_r == (RING_AW+1)'(RING_DEPTH));
  assign ring_we   = step && !high;

  // threshold and level compare
  always_comb begin
    logic [SAMPLE_BITS:0] mid;
    mid = {1'b0, SAMPLE_MAX} + {1'b0, floor_r};
    if (adaptive_enable_r && ring_full) begin
      thr = mid[SAMPLE_BITS:1];
    end else begin
      thr = base_threshold_r;
    end
    high = (in_sample_r > thr);
  end

  // tick counter, led and watchdog clear
  always_comb begin
    count8_t tc_inc;
    tc_inc         = tick_count_r + 8'd1;
    tick_count_nxt = tc_inc;
    led_level_nxt  = led_level_r;
    wd_clear       = 1'b0;
    if ((tc_inc == half_second_ticks_r) ||
        ((tc_inc == short_period_ticks_r) && pending_r)) begin
      led_level_nxt  = !led_level_r;
      wd_clear       = 1'b1;
      tick_count_nxt = '0;
    end
  end

  // repeater keying
  always_comb begin
    count8_t hr_inc;
    hr_inc          = high_run_r + 8'd1;
    keyed_ticks_nxt = keyed_ticks_r;
    tx_keyed_nxt    = tx_keyed_r;
    if (tx_keyed_r && (keyed_ticks_r != KEYED_MAX)) begin
      keyed_ticks_nxt = keyed_ticks_r + 16'd1;
    end
    if (high) begin
      high_run_nxt = hr_inc;
      if (hr_inc >= activation_count_r) begin
        tx_keyed_nxt    = 1'b1;
        keyed_ticks_nxt = '0;
        high_run_nxt    = '0;
      end
    end else begin
      high_run_nxt = '0;
      if (keyed_ticks_nxt >= hold_ticks_r) begin
        tx_keyed_nxt = 1'b0;
      end
    end
  end

  // noise ring bookkeeping on low ticks
  always_comb begin
    sample_t          oldest;
    logic [SUM_W-1:0] sum_new;
    logic [RING_AW:0] fill_new;
    oldest        = ring_full ? ring_oldest : '0;
    fill_new      = ring_full ? ring_fill_r : ring_fill_r + 1'b1;
    sum_new       = ring_sum_r + SUM_W'(in_sample_r) - SUM_W'(oldest);
    ring_pos_nxt  = ring_pos_r;
    ring_fill_nxt = ring_fill_r;
    ring_sum_nxt  = ring_sum_r;
    floor_nxt     = floor_r;
    if (ring_we) begin
      ring_pos_nxt  = ring_pos_r + 1'b1;
      ring_fill_nxt = fill_new;
      ring_sum_nxt  = sum_new;
      if (fill_new == (RING_AW+1)'(RING_DEPTH)) begin
        floor_nxt = sum_new[SUM_W-1:RING_AW];
      end
    end
  end

  // ask decoder, sync and bit ticks alternate
  always_comb begin
    logic slot_t;
    busy_nxt      = busy_r;
    slot_t        = slot_r;
    bit_total_nxt = bit_total_r;
    pending_nxt   = pending_r;
    if (!busy_r && high) begin
      slot_t   = 1'b1;
      busy_nxt = 1'b1;
    end
    if (slot_t) begin
      if (cur_level_r != high) begin
        if (bit_total_r != BIT_TOTAL_MAX) begin
          bit_total_nxt = bit_total_r + 1'b1;
        end
      end else begin
        busy_nxt = 1'b0;
        if (bit_total_r == COMMAND_BITS) begin
          pending_nxt = !pending_r;
        end
        bit_total_nxt = '0;
      end
      slot_nxt = 1'b0;
    end else begin
      slot_nxt = 1'b1;
    end
  end

  // noise ring storage, read address follows the ring position
  rsq_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_pos_r),
    .wdata (in_sample_r),
    .raddr (ring_pos_nxt),
    .rdata (ring_oldest)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_threshold_r     <= RST_BASE_THRESHOLD;
      adaptive_enable_r    <= 1'b0;
      activation_count_r   <= RST_ACTIVATION_COUNT;
      hold_ticks_r         <= RST_HOLD_TICKS;
      half_second_ticks_r  <= RST_HALF_SECOND_TICKS;
      short_period_ticks_r <= RST_SHORT_PERIOD_TICKS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BASE_THRESHOLD:     base_threshold_r     <= cfg_data[SAMPLE_BITS-1:0];
        REG_ADAPTIVE_ENABLE:    adaptive_enable_r    <= cfg_data[0];
        REG_ACTIVATION_COUNT:   activation_count_r   <= cfg_data[7:0];
        REG_HOLD_TICKS:         hold_ticks_r         <= cfg_data[KEYED_W-1:0];
        REG_HALF_SECOND_TICKS:  half_second_ticks_r  <= cfg_data[7:0];
        REG_SHORT_PERIOD_TICKS: short_period_ticks_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_sample_r <= in_adc_sample;
    end
  end

  // per-tick state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r  <= '0;
      led_level_r   <= 1'b0;
      wd_pin_r      <= 1'b0;
      pending_r     <= 1'b0;
      ring_pos_r    <= '0;
      ring_fill_r   <= '0;
      ring_sum_r    <= '0;
      floor_r       <= '0;
      high_run_r    <= '0;
      keyed_ticks_r <= '0;
      tx_keyed_r    <= 1'b0;
      cur_level_r   <= 1'b0;
      busy_r        <= 1'b0;
      slot_r        <= 1'b0;
      bit_total_r   <= '0;
    end else if (step) begin
      tick_count_r  <= tick_count_nxt;
      led_level_r   <= led_level_nxt;
      wd_pin_r      <= !wd_pin_r;
      pending_r     <= pending_nxt;
      ring_pos_r    <= ring_pos_nxt;
      ring_fill_r   <= ring_fill_nxt;
      ring_sum_r    <= ring_sum_nxt;
      floor_r       <= floor_nxt;
      high_run_r    <= high_run_nxt;
      keyed_ticks_r <= keyed_ticks_nxt;
      tx_keyed_r    <= tx_keyed_nxt;
      cur_level_r   <= high;
      busy_r        <= busy_nxt;
      slot_r        <= slot_nxt;
      bit_total_r   <= bit_total_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_ptt_on          <= tx_keyed_nxt;
      out_signal_high     <= high;
      out_command_pending <= pending_nxt;
      out_led_on          <= led_level_nxt;
      out_watchdog_pin    <= !wd_pin_r;
      out_watchdog_clear  <= wd_clear;
      out_threshold_used  <= thr;
      out_noise_floor     <= floor_nxt;
    end
  end

endmodule

/* rtl/core/rsq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
